@@ hw/rtl/dwpi_pkg.sv @@
// shared types, constants and register indexes for the two-wheel pi speed controller
// used by dwpi_div, dwpi_ctrl, dwpi_datapath and dual_wheel_pi_speed_control
package dwpi_pkg;

	localparam int unsigned SPEED_W    = 16;
	localparam int unsigned DUTY_W     = 16;
	localparam int unsigned GAIN_W     = 32;
	localparam int unsigned ERR_W      = 21;
	localparam int unsigned INTEG_W    = 40;
	localparam int unsigned DIV_W      = 31;
	localparam int unsigned DIV_CNT_W  = 5;
	localparam int unsigned PROD_W     = 54;
	localparam int unsigned ACC_W      = 74;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned STATE_W    = 3;

	typedef logic [SPEED_W-1:0]        dwpi_speed_t;
	typedef logic [DUTY_W-1:0]         dwpi_duty_t;
	typedef logic [GAIN_W-1:0]         dwpi_gain_t;
	typedef logic [DIV_W-1:0]          dwpi_div_t;
	typedef logic signed [ERR_W-1:0]   dwpi_err_t;
	typedef logic signed [INTEG_W-1:0] dwpi_integ_t;
	typedef logic signed [PROD_W-1:0]  dwpi_prod_t;
	typedef logic signed [ACC_W-1:0]   dwpi_acc_t;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN_LEFT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN_LEFT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN_RIGHT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN_RIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_DUTY        = 3'd4;

	// register reset values
	localparam dwpi_gain_t RST_PROP_GAIN  = 32'd5033165;
	localparam dwpi_gain_t RST_INTEG_GAIN = 32'd3355;
	localparam dwpi_duty_t RST_IDLE_DUTY  = 16'd3999;

	// error scaling and limits
	localparam logic [14:0] ERR_SCALE   = 15'd20000;
	localparam dwpi_err_t   ERR_MAX     = 21'sd20000;
	localparam dwpi_err_t   ERR_MIN     = 21'h10_0000;
	localparam dwpi_div_t   ERR_MAX_MAG = 31'd20000;
	localparam dwpi_div_t   ERR_MIN_MAG = 31'd1048576;

	localparam dwpi_integ_t INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
	localparam dwpi_integ_t INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};
	localparam dwpi_duty_t  DUTY_MAX  = 16'hFFFF;

	// multiply-accumulate step codes
	localparam logic [1:0] MAC_PROP     = 2'd0;
	localparam logic [1:0] MAC_INTEG_LO = 2'd1;
	localparam logic [1:0] MAC_INTEG_HI = 2'd2;
	localparam logic [1:0] MAC_ADD_HI   = 2'd3;

	localparam logic WHEEL_LEFT  = 1'b0;
	localparam logic WHEEL_RIGHT = 1'b1;

	typedef struct packed {
		dwpi_speed_t target_speed;
		dwpi_speed_t speed_left;
		dwpi_speed_t speed_right;
	} dwpi_in_t;

	typedef struct packed {
		dwpi_duty_t duty_left;
		dwpi_duty_t duty_right;
	} dwpi_out_t;

	typedef struct packed {
		dwpi_gain_t prop_gain_left;
		dwpi_gain_t integ_gain_left;
		dwpi_gain_t prop_gain_right;
		dwpi_gain_t integ_gain_right;
		dwpi_duty_t idle_duty;
	} dwpi_gains_t;

	typedef struct packed {
		logic       capture;
		logic       div_start;
		logic       err_latch;
		logic       mac_en;
		logic [1:0] mac_sel;
		logic       finish;
		logic       wheel;
		logic       idle_load;
		logic       out_load;
	} dwpi_cmd_t;

	typedef struct packed {
		logic target_zero;
		logic div_done;
		logic out_free;
	} dwpi_sts_t;

endpackage

@@ hw/rtl/dual_wheel_pi_speed_control.sv @@
// top level of the two-wheel pi speed controller: config registers, controller, datapath
// depends on dwpi_pkg, dwpi_ctrl, dwpi_datapath, dwpi_div
//
//   channel  dir  handshake                 payload
//   speed    in   speed_valid/speed_stall   target_speed, speed_left, speed_right
//   duty     out  duty_valid/duty_stall     duty_left, duty_right
//   cfg      in   cfg_we (no wait)          cfg_idx, cfg_wdata
//
// one beat in gives one beat out; a nonzero target runs the divider and multiply-accumulate
// steps, a zero target loads the idle duty, and the next beat is taken in the cycle after
// the result is loaded; the shared 31-step restoring divider runs once per wheel,
// plus four multiply-accumulate steps per wheel on a single 33x21 multiplier
// the result register lets the next beat in while the last one waits on duty_stall
// arst_n clears the controller, the integrals and the gains to their defaults
module dual_wheel_pi_speed_control (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration writes
	input  logic                                cfg_we,
	input  logic [dwpi_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [dwpi_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	// speed beats in
	input  logic                                speed_valid,
	output logic                                speed_stall,
	input  dwpi_pkg::dwpi_in_t                  speed,
	// duty beats out
	output logic                                duty_valid,
	input  logic                                duty_stall,
	output dwpi_pkg::dwpi_out_t                 duty
);

	dwpi_pkg::dwpi_gains_t gains_q;
	dwpi_pkg::dwpi_cmd_t   cmd;
	dwpi_pkg::dwpi_sts_t   sts;

	// register file; writes to unused indexes fall through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.prop_gain_left   <= dwpi_pkg::RST_PROP_GAIN;
			gains_q.integ_gain_left  <= dwpi_pkg::RST_INTEG_GAIN;
			gains_q.prop_gain_right  <= dwpi_pkg::RST_PROP_GAIN;
			gains_q.integ_gain_right <= dwpi_pkg::RST_INTEG_GAIN;
			gains_q.idle_duty        <= dwpi_pkg::RST_IDLE_DUTY;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				dwpi_pkg::CFG_PROP_GAIN_LEFT:   gains_q.prop_gain_left   <= cfg_wdata;
				dwpi_pkg::CFG_INTEG_GAIN_LEFT:  gains_q.integ_gain_left  <= cfg_wdata;
				dwpi_pkg::CFG_PROP_GAIN_RIGHT:  gains_q.prop_gain_right  <= cfg_wdata;
				dwpi_pkg::CFG_INTEG_GAIN_RIGHT: gains_q.integ_gain_right <= cfg_wdata;
				dwpi_pkg::CFG_IDLE_DUTY:        gains_q.idle_duty        <= cfg_wdata[dwpi_pkg::DUTY_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer: one beat at a time, left wheel then right wheel
	dwpi_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.speed_valid (speed_valid),
		.speed_stall (speed_stall),
		.sts         (sts),
		.cmd         (cmd)
	);

	// arithmetic, wheel state and the result register
	dwpi_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.gains      (gains_q),
		.speed      (speed),
		.duty_valid (duty_valid),
		.duty_stall (duty_stall),
		.duty       (duty)
	);

endmodule

@@ hw/rtl/dwpi_div.sv @@
// restoring unsigned divider, one quotient bit per cycle
// depends on dwpi_pkg
module dwpi_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  dwpi_pkg::dwpi_div_t dividend,
	input  dwpi_pkg::dwpi_speed_t divisor,
	output logic                done,
	output dwpi_pkg::dwpi_div_t quotient
);

	localparam logic [dwpi_pkg::DIV_CNT_W-1:0] LAST_STEP = (dwpi_pkg::DIV_CNT_W)'(dwpi_pkg::DIV_W - 1);

	dwpi_pkg::dwpi_div_t   quo_q;
	dwpi_pkg::dwpi_speed_t rem_q;
	dwpi_pkg::dwpi_speed_t dsr_q;
	logic [dwpi_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [dwpi_pkg::SPEED_W:0] rem_sh;
	logic [dwpi_pkg::SPEED_W:0] rem_sub;
	logic                       ge;

	assign rem_sh  = {rem_q, quo_q[dwpi_pkg::DIV_W-1]};
	assign ge      = rem_sh >= {1'b0, dsr_q};
	assign rem_sub = rem_sh - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST_STEP) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[dwpi_pkg::DIV_W-2:0], ge};
			rem_q <= ge ? rem_sub[dwpi_pkg::SPEED_W-1:0] : rem_sh[dwpi_pkg::SPEED_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ hw/rtl/dwpi_ctrl.sv @@
// sequencing state machine: accept, divide, multiply-accumulate per wheel, deliver
// depends on dwpi_pkg
module dwpi_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                speed_valid,
	output logic                speed_stall,
	input  dwpi_pkg::dwpi_sts_t sts,
	output dwpi_pkg::dwpi_cmd_t cmd
);

	localparam logic [dwpi_pkg::STATE_W-1:0] S_IDLE  = 3'd0;
	localparam logic [dwpi_pkg::STATE_W-1:0] S_START = 3'd1;
	localparam logic [dwpi_pkg::STATE_W-1:0] S_DIV   = 3'd2;
	localparam logic [dwpi_pkg::STATE_W-1:0] S_MAC   = 3'd3;
	localparam logic [dwpi_pkg::STATE_W-1:0] S_FIN   = 3'd4;
	localparam logic [dwpi_pkg::STATE_W-1:0] S_OUT   = 3'd5;

	logic [dwpi_pkg::STATE_W-1:0] state_q, state_d;
	logic [1:0]                   mac_q, mac_d;
	logic                         wheel_q, wheel_d;

	always_comb begin
		state_d     = state_q;
		mac_d       = mac_q;
		wheel_d     = wheel_q;
		cmd         = '0;
		cmd.wheel   = wheel_q;
		cmd.mac_sel = mac_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.capture = speed_valid;
				wheel_d     = dwpi_pkg::WHEEL_LEFT;
				if (speed_valid) begin
					state_d = S_START;
				end
			end
			S_START: begin
				if (sts.target_zero) begin
					cmd.idle_load = 1'b1;
					state_d       = S_OUT;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end
			end
			S_DIV: begin
				if (sts.div_done) begin
					cmd.err_latch = 1'b1;
					mac_d         = dwpi_pkg::MAC_PROP;
					state_d       = S_MAC;
				end
			end
			S_MAC: begin
				cmd.mac_en = 1'b1;
				mac_d      = mac_q + 1'b1;
				if (mac_q == dwpi_pkg::MAC_ADD_HI) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				if (wheel_q == dwpi_pkg::WHEEL_RIGHT) begin
					state_d = S_OUT;
				end else begin
					wheel_d = dwpi_pkg::WHEEL_RIGHT;
					state_d = S_START;
				end
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mac_q   <= dwpi_pkg::MAC_PROP;
			wheel_q <= dwpi_pkg::WHEEL_LEFT;
		end else begin
			state_q <= state_d;
			mac_q   <= mac_d;
			wheel_q <= wheel_d;
		end
	end

	assign speed_stall = (state_q != S_IDLE);

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> state_q == S_DIV)
		else $error("divider finished outside of the divide state");

	a_out_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> (state_q == S_IDLE && !speed_stall))
		else $error("controller not ready after result delivery");

	a_right_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && cmd.wheel == dwpi_pkg::WHEEL_RIGHT) |=> state_q == S_OUT)
		else $error("right wheel finish did not lead to delivery");

endmodule

@@ hw/rtl/dwpi_datapath.sv @@
// operand registers, error divider, shared multiplier, accumulator, integrals and
// result register; depends on dwpi_pkg and dwpi_div
module dwpi_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dwpi_pkg::dwpi_cmd_t   cmd,
	output dwpi_pkg::dwpi_sts_t   sts,
	input  dwpi_pkg::dwpi_gains_t gains,
	input  dwpi_pkg::dwpi_in_t    speed,
	output logic                  duty_valid,
	input  logic                  duty_stall,
	output dwpi_pkg::dwpi_out_t   duty
);

	dwpi_pkg::dwpi_in_t    item_q;
	logic                  neg_q;
	dwpi_pkg::dwpi_err_t   err_q;
	dwpi_pkg::dwpi_prod_t  prod_q;
	dwpi_pkg::dwpi_acc_t   acc_q;
	dwpi_pkg::dwpi_integ_t integ_l_q, integ_r_q;
	dwpi_pkg::dwpi_duty_t  duty_l_q, duty_r_q;
	dwpi_pkg::dwpi_out_t   out_q;
	logic                  out_valid_q;

	dwpi_pkg::dwpi_speed_t speed_sel;
	logic [dwpi_pkg::SPEED_W:0] diff, diff_abs;
	logic                  diff_neg;
	dwpi_pkg::dwpi_div_t   dividend;
	dwpi_pkg::dwpi_div_t   quotient;
	logic                  div_done;
	dwpi_pkg::dwpi_err_t   err_next;

	dwpi_pkg::dwpi_gain_t  kp, ki;
	dwpi_pkg::dwpi_integ_t integ_sel;
	logic signed [dwpi_pkg::GAIN_W:0]  mul_a;
	logic signed [dwpi_pkg::ERR_W-1:0] mul_b;
	dwpi_pkg::dwpi_prod_t  product;
	dwpi_pkg::dwpi_acc_t   acc_next;

	logic [dwpi_pkg::INTEG_W:0] integ_sum;
	dwpi_pkg::dwpi_integ_t integ_next;
	dwpi_pkg::dwpi_duty_t  duty_calc;

	// error numerator magnitude: 20000 * |target - speed|
	assign speed_sel = cmd.wheel ? item_q.speed_right : item_q.speed_left;
	assign diff      = {1'b0, item_q.target_speed} - {1'b0, speed_sel};
	assign diff_neg  = diff[dwpi_pkg::SPEED_W];
	assign diff_abs  = diff_neg ? ('0 - diff) : diff;
	assign dividend  = dwpi_pkg::dwpi_div_t'(diff_abs[dwpi_pkg::SPEED_W-1:0])
	                 * dwpi_pkg::dwpi_div_t'(dwpi_pkg::ERR_SCALE);

	dwpi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (item_q.target_speed),
		.done     (div_done),
		.quotient (quotient)
	);

	// signed quotient with clamp
	always_comb begin
		if (!neg_q) begin
			err_next = (quotient > dwpi_pkg::ERR_MAX_MAG) ? dwpi_pkg::ERR_MAX
			         : dwpi_pkg::dwpi_err_t'(quotient);
		end else begin
			err_next = (quotient > dwpi_pkg::ERR_MIN_MAG) ? dwpi_pkg::ERR_MIN
			         : -(dwpi_pkg::dwpi_err_t'(quotient));
		end
	end

	assign kp        = cmd.wheel ? gains.prop_gain_right  : gains.prop_gain_left;
	assign ki        = cmd.wheel ? gains.integ_gain_right : gains.integ_gain_left;
	assign integ_sel = cmd.wheel ? integ_r_q : integ_l_q;

	always_comb begin
		mul_a = $signed({1'b0, ki});
		unique case (cmd.mac_sel)
			dwpi_pkg::MAC_PROP: begin
				mul_a = $signed({1'b0, kp});
				mul_b = err_q;
			end
			dwpi_pkg::MAC_INTEG_LO: begin
				mul_b = $signed({1'b0, integ_sel[19:0]});
			end
			dwpi_pkg::MAC_INTEG_HI: begin
				mul_b = $signed({integ_sel[dwpi_pkg::INTEG_W-1], integ_sel[39:20]});
			end
			default: begin
				mul_b = '0;
			end
		endcase
	end

	assign product = mul_a * mul_b;

	// accumulate the product registered on the step before
	always_comb begin
		unique case (cmd.mac_sel)
			dwpi_pkg::MAC_PROP:     acc_next = '0;
			dwpi_pkg::MAC_INTEG_LO: acc_next = acc_q + dwpi_pkg::dwpi_acc_t'(prod_q);
			dwpi_pkg::MAC_INTEG_HI: acc_next = acc_q + dwpi_pkg::dwpi_acc_t'(prod_q);
			default:                acc_next = acc_q + (dwpi_pkg::dwpi_acc_t'(prod_q) <<< 20);
		endcase
	end

	// duty clamp from q24 drive
	always_comb begin
		if (acc_q[dwpi_pkg::ACC_W-1]) begin
			duty_calc = '0;
		end else if (|acc_q[dwpi_pkg::ACC_W-2:40]) begin
			duty_calc = dwpi_pkg::DUTY_MAX;
		end else begin
			duty_calc = acc_q[39:24];
		end
	end

	// saturating integral update
	assign integ_sum = {integ_sel[dwpi_pkg::INTEG_W-1], integ_sel}
	                 + {{(dwpi_pkg::INTEG_W + 1 - dwpi_pkg::ERR_W){err_q[dwpi_pkg::ERR_W-1]}}, err_q};

	always_comb begin
		if (integ_sum[dwpi_pkg::INTEG_W] != integ_sum[dwpi_pkg::INTEG_W-1]) begin
			integ_next = integ_sum[dwpi_pkg::INTEG_W] ? dwpi_pkg::INTEG_MIN : dwpi_pkg::INTEG_MAX;
		end else begin
			integ_next = integ_sum[dwpi_pkg::INTEG_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= speed;
		end
		if (cmd.div_start) begin
			neg_q <= diff_neg;
		end
		if (cmd.err_latch) begin
			err_q <= err_next;
		end
		if (cmd.mac_en) begin
			prod_q <= product;
			acc_q  <= acc_next;
		end
		if (cmd.idle_load) begin
			duty_l_q <= gains.idle_duty;
			duty_r_q <= gains.idle_duty;
		end else if (cmd.finish) begin
			if (cmd.wheel) begin
				duty_r_q <= duty_calc;
			end else begin
				duty_l_q <= duty_calc;
			end
		end
		if (cmd.out_load) begin
			out_q.duty_left  <= duty_l_q;
			out_q.duty_right <= duty_r_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_l_q <= '0;
			integ_r_q <= '0;
		end else if (cmd.idle_load) begin
			integ_l_q <= '0;
			integ_r_q <= '0;
		end else if (cmd.finish) begin
			if (cmd.wheel) begin
				integ_r_q <= integ_next;
			end else begin
				integ_l_q <= integ_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!duty_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.target_zero = (item_q.target_speed == '0);
	assign sts.div_done    = div_done;
	assign sts.out_free    = !out_valid_q || !duty_stall;

	assign duty_valid = out_valid_q;
	assign duty       = out_q;

	a_zero_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.idle_load |=> (integ_l_q == '0 && integ_r_q == '0))
		else $error("integrals not cleared on zero target");

	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.err_latch |=> (err_q <= dwpi_pkg::ERR_MAX && err_q >= dwpi_pkg::ERR_MIN))
		else $error("wheel error outside its clamp range");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> duty_valid)
		else $error("result load did not raise duty_valid");

endmodule
